// ===== src/bft_pkg.sv =====
// Package with shared types, constants and codes of the flow table.
`timescale 1ns / 1ps
package bft_pkg;
   localparam int DefTableEntries = 32;
   localparam int SlotW           = 6;
   localparam int KeyW            = 104;
   localparam int TimeW           = 48;
   localparam int UsPerSec        = 1000000;

   typedef enum logic [1:0] {
      KIND_PACKET = 2'd0,
      KIND_EXPIRE = 2'd1,
      KIND_FLUSH  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_FWD_HIT = 3'd0,
      ST_REV_HIT = 3'd1,
      ST_CREATED = 3'd2,
      ST_DROPPED = 3'd3,
      ST_EXPIRED = 3'd4,
      ST_FLUSHED = 3'd5,
      ST_DONE    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_TCP_TIMEOUT   = 2'd0,
      CSR_OTHER_TIMEOUT = 2'd1,
      CSR_FLOW_LIMIT    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FWD,
      S_REV,
      S_DECIDE,
      S_SCAN,
      S_DONE
   } state_type;

   localparam logic [7:0] ProtoTcp = 8'd6;
endpackage

// ===== src/bft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bft_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/bft_timeout.sv =====
// Registered conversion of a timeout in seconds to microseconds.
`timescale 1ns / 1ps
module bft_timeout
   import bft_pkg::*;
(
   input  logic             clock,
   input  logic [15:0]      tcp_sec,
   input  logic [15:0]      other_sec,
   output logic [TimeW-1:0] tcp_us_ff,
   output logic [TimeW-1:0] other_us_ff
);
   localparam logic [19:0] UsConst = 20'(UsPerSec);
   logic [35:0] tcp_mul, other_mul;

   assign tcp_mul   = tcp_sec * UsConst;
   assign other_mul = other_sec * UsConst;

   always_ff @(posedge clock) begin
      tcp_us_ff   <= TimeW'(tcp_mul);
      other_us_ff <= TimeW'(other_mul);
   end
endmodule

// ===== src/bidirectional_flow_table_top.sv =====
// Top level of the bidirectional five-tuple flow table.
//
//  channel | ports                  | handshake
//  req     | req_kind .. req_now_us | start & !busy
//  rsp     | rsp_status .. rsp_last | rsp_strobe, one cycle, no stall
//  csr     | csr_index, csr_data    | csr_valid & csr_ready
//
// Each packet, expire or flush request walks slots one per cycle through the
// key RAM read port. A packet keeps busy high for a forward and a reverse pass
// over all slots, then decide; a hit ends the request early. Expire and flush
// keep busy high for one walk and a done step; removal results come out during
// the walk without holding it. The single read port of the key and time RAMs
// paces the walk. The receiver cannot stall results. Reset clears valid bits,
// active count, walk state and CSRs; RAM contents are undefined until written.
`timescale 1ns / 1ps
module bidirectional_flow_table_top
   import bft_pkg::*;
#(
   parameter int TableEntries = DefTableEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_proto_num,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [47:0] req_now_us,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_is_forward,
   output logic [5:0]  rsp_slot,
   output logic        rsp_closed,
   output logic [31:0] rsp_flow_src_ip,
   output logic [31:0] rsp_flow_dst_ip,
   output logic [15:0] rsp_flow_src_port,
   output logic [15:0] rsp_flow_dst_port,
   output logic [7:0]  rsp_flow_proto,
   output logic [5:0]  rsp_removed_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int AW = $clog2(TableEntries);

   // registers
   logic [15:0] tcp_to_ff, other_to_ff;
   logic [5:0]  limit_ff;
   logic [TimeW-1:0] tcp_us, other_us;

   state_type state_ff, state_in;
   logic [TableEntries-1:0] valid_ff, valid_in;
   logic [5:0]  active_ff, active_in, count_ff, count_in;
   logic [AW:0] idx_ff, idx_in;       // read address issued
   logic        pend_ff, pend_in;     // read data for slot idx_ff-1 is valid

   logic [1:0]  kind_ff;
   logic [31:0] sip_ff, dip_ff;
   logic [15:0] sp_ff, dp_ff;
   logic [7:0]  proto_ff;
   logic        closing_ff;
   logic [TimeW-1:0] now_ff;

   // RAMs
   logic          key_we, time_we;
   logic [AW-1:0] key_waddr, rd_addr, time_waddr;
   logic [KeyW-1:0] key_wdata, key_rdata;
   logic [TimeW-1:0] time_rdata;

   bft_ram #(.Width(KeyW), .Depth(TableEntries)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(rd_addr), .rd_data(key_rdata));
   bft_ram #(.Width(TimeW), .Depth(TableEntries)) u_time_ram (
      .clock(clock), .wr_en(time_we), .wr_addr(time_waddr), .wr_data(now_ff),
      .rd_addr(rd_addr), .rd_data(time_rdata));
   bft_timeout u_timeout (
      .clock(clock), .tcp_sec(tcp_to_ff), .other_sec(other_to_ff),
      .tcp_us_ff(tcp_us), .other_us_ff(other_us));

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rd_addr   = idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_to_ff   <= 16'd120;
         other_to_ff <= 16'd120;
         limit_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TCP_TIMEOUT:   tcp_to_ff   <= csr_data;
            CSR_OTHER_TIMEOUT: other_to_ff <= csr_data;
            CSR_FLOW_LIMIT:    limit_ff    <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff    <= req_kind;
         sip_ff     <= req_src_ip;
         dip_ff     <= req_dst_ip;
         sp_ff      <= req_src_port;
         dp_ff      <= req_dst_port;
         proto_ff   <= req_proto_num;
         closing_ff <= (req_tcp_flag_bits[0] | req_tcp_flag_bits[2]);
         now_ff     <= req_now_us;
      end
   end

   // slot whose data is on the read port
   logic [AW-1:0] cur;
   logic [31:0] k_sip, k_dip;
   logic [15:0] k_sp, k_dp;
   logic [7:0]  k_pr;
   logic fwd_match, rev_match, cur_valid, at_end, expire_hit;
   logic [TimeW-1:0] tmo;
   logic [TimeW:0] deadline;
   logic [AW:0] free_idx;
   logic [5:0] eff_limit;
   logic [AW:0] last_idx;

   assign cur = AW'(idx_ff - 1'b1);
   assign {k_sip, k_dip, k_sp, k_dp, k_pr} = key_rdata;
   assign cur_valid = valid_ff[cur];
   assign fwd_match = cur_valid && k_sip == sip_ff && k_dip == dip_ff &&
                      k_sp == sp_ff && k_dp == dp_ff && k_pr == proto_ff;
   assign rev_match = cur_valid && k_sip == dip_ff && k_dip == sip_ff &&
                      k_sp == dp_ff && k_dp == sp_ff && k_pr == proto_ff;
   assign tmo       = (k_pr == ProtoTcp) ? tcp_us : other_us;
   assign deadline  = {1'b0, time_rdata} + {1'b0, tmo};
   assign expire_hit = cur_valid &&
                       ((kind_ff == KIND_FLUSH) || ({1'b0, now_ff} >= deadline));
   assign last_idx  = (AW+1)'(TableEntries);
   assign at_end    = pend_ff && (idx_ff == last_idx);
   assign eff_limit = (limit_ff == 6'd0 || 32'(limit_ff) > TableEntries) ?
                      6'(TableEntries) : limit_ff;

   always_comb begin
      free_idx = last_idx;
      for (int i = TableEntries - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = (AW+1)'(i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (kind_type'(req_kind))
                  KIND_PACKET: state_in = S_FWD;
                  KIND_EXPIRE, KIND_FLUSH: state_in = S_SCAN;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FWD:    if (pend_ff && fwd_match) state_in = S_IDLE;
                   else if (at_end) state_in = S_REV;
         S_REV:    if (pend_ff && rev_match) state_in = S_IDLE;
                   else if (at_end) state_in = S_DECIDE;
         S_DECIDE: state_in = S_IDLE;
         S_SCAN:   if (at_end) state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      valid_in = valid_ff; active_in = active_ff; count_in = count_ff;
      idx_in = idx_ff; pend_in = pend_ff;
      key_we = 1'b0; time_we = 1'b0;
      key_waddr = free_idx[AW-1:0]; time_waddr = cur;
      key_wdata = {sip_ff, dip_ff, sp_ff, dp_ff, proto_ff};
      rsp_strobe = 1'b0; rsp_status = ST_DONE; rsp_is_forward = 1'b0;
      rsp_slot = '0; rsp_closed = 1'b0; rsp_flow_src_ip = '0; rsp_flow_dst_ip = '0;
      rsp_flow_src_port = '0; rsp_flow_dst_port = '0; rsp_flow_proto = '0;
      rsp_removed_count = '0; rsp_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0; pend_in = 1'b0; count_in = '0;
         end
         S_FWD, S_REV: begin
            if (pend_ff && ((state_ff == S_FWD) ? fwd_match : rev_match)) begin
               time_we = 1'b1; time_waddr = cur;
               rsp_strobe = 1'b1; rsp_last = 1'b1;
               rsp_status = (state_ff == S_FWD) ? ST_FWD_HIT : ST_REV_HIT;
               rsp_is_forward = (state_ff == S_FWD);
               rsp_slot = 6'(cur); rsp_closed = closing_ff;
               {rsp_flow_src_ip, rsp_flow_dst_ip, rsp_flow_src_port,
                rsp_flow_dst_port, rsp_flow_proto} = key_rdata;
               if (closing_ff) begin
                  valid_in[cur] = 1'b0;
                  if (active_ff != 0) active_in = active_ff - 1'b1;
               end
            end else if (at_end) begin
               idx_in = '0; pend_in = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1; pend_in = 1'b1;
            end
         end
         S_DECIDE: begin
            rsp_strobe = 1'b1; rsp_last = 1'b1;
            if (active_ff >= eff_limit || free_idx == last_idx) begin
               rsp_status = ST_DROPPED;
            end else begin
               key_we = 1'b1; time_we = 1'b1;
               key_waddr = free_idx[AW-1:0]; time_waddr = free_idx[AW-1:0];
               rsp_status = ST_CREATED; rsp_is_forward = 1'b1;
               rsp_slot = 6'(free_idx); rsp_closed = closing_ff;
               rsp_flow_src_ip = sip_ff; rsp_flow_dst_ip = dip_ff;
               rsp_flow_src_port = sp_ff; rsp_flow_dst_port = dp_ff;
               rsp_flow_proto = proto_ff;
               if (!closing_ff) begin
                  valid_in[free_idx[AW-1:0]] = 1'b1;
                  active_in = active_ff + 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && expire_hit) begin
               rsp_strobe = 1'b1;
               rsp_status = (kind_ff == KIND_FLUSH) ? ST_FLUSHED : ST_EXPIRED;
               rsp_slot = 6'(cur); rsp_closed = 1'b1;
               {rsp_flow_src_ip, rsp_flow_dst_ip, rsp_flow_src_port,
                rsp_flow_dst_port, rsp_flow_proto} = key_rdata;
               valid_in[cur] = 1'b0;
               if (active_ff != 0) active_in = active_ff - 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (!at_end) begin
               idx_in = idx_ff + 1'b1; pend_in = 1'b1;
            end
         end
         S_DONE: begin
            rsp_strobe = 1'b1; rsp_last = 1'b1;
            rsp_status = ST_DONE; rsp_removed_count = count_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; active_ff <= '0; count_ff <= '0;
         idx_ff <= '0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; active_ff <= active_in;
         count_ff <= count_in; idx_ff <= idx_in; pend_ff <= pend_in;
      end
   end
endmodule
